// File: sv/lfpid_pkg.sv
`default_nettype none

package lfpid_pkg;

   // sensor array
   localparam int SENSOR_W     = 9;
   localparam int SENSOR_COUNT = 9;
   localparam int CENTRE       = (SENSOR_COUNT - 1) / 2;

   // weighted sum stays within +/-10, so a 4 bit magnitude and count suffice
   localparam int SUM_W = 6;
   localparam int CNT_W = 4;
   localparam int MAG_W = 4;
   localparam int ERR_W = 4;

   // arithmetic widths
   localparam int GAIN_W = 16;
   localparam int INT_W  = 24;
   localparam int A_W    = INT_W + 1;
   localparam int PROD_W = A_W + GAIN_W;
   localparam int SAT_W  = PROD_W - 8;
   localparam int ACC_W  = 27;
   localparam int LVL_W  = ACC_W - 8;
   localparam int LOST_W = 11;
   localparam int DUTY_W = 8;

   localparam int INT_MAX_V = 2 ** (INT_W - 1) - 1;
   localparam int INT_MIN_V = -(2 ** (INT_W - 1));

   localparam logic [DUTY_W-1:0] DUTY_MAX = '1;
   localparam logic [LOST_W-1:0] LOST_MAX = '1;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P         = 3'd0,
      CSR_GAIN_I         = 3'd1,
      CSR_GAIN_D         = 3'd2,
      CSR_BASE_SPEED     = 3'd3,
      CSR_RECOVERY_SPEED = 3'd4,
      CSR_LOST_LIMIT     = 3'd5,
      CSR_REVERSE_DRIVE  = 3'd6,
      CSR_BRAKE_DUTY     = 3'd7
   } csr_index_type;

   localparam logic [GAIN_W-1:0] RST_GAIN_P         = 16'd2560;
   localparam logic [GAIN_W-1:0] RST_GAIN_I         = 16'd0;
   localparam logic [GAIN_W-1:0] RST_GAIN_D         = 16'd0;
   localparam logic [DUTY_W-1:0] RST_BASE_SPEED     = 8'd180;
   localparam logic [DUTY_W-1:0] RST_RECOVERY_SPEED = 8'd170;
   localparam logic [LOST_W-1:0] RST_LOST_LIMIT     = 11'd1000;
   localparam logic [DUTY_W-1:0] RST_REVERSE_DRIVE  = 8'd200;
   localparam logic [DUTY_W-1:0] RST_BRAKE_DUTY     = 8'd230;

   typedef enum logic [1:0] {
      DIR_BRAKE = 2'd0,
      DIR_FWD   = 2'd1,
      DIR_REV   = 2'd2
   } dir_type;

   typedef struct packed {
      dir_type           dir;
      logic [DUTY_W-1:0] duty;
   } motor_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC_I,
      ST_ACC_D,
      ST_MIX_L,
      ST_MIX_R,
      ST_DRV_R,
      ST_DONE
   } state_type;

   function automatic logic [SENSOR_COUNT-1:0] centre_mask();
      logic [SENSOR_COUNT-1:0] m;
      m = '0;
      for (int k = 0; k < SENSOR_COUNT; k++) begin
         if (k >= CENTRE - 2 && k <= CENTRE + 2) begin
            m[k] = 1'b1;
         end
      end
      return m;
   endfunction

   localparam logic [SENSOR_COUNT-1:0] CENTRE_MASK = centre_mask();

endpackage

`default_nettype wire

// File: sv/lfpid_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module lfpid_div import lfpid_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [MAG_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic                  done,
   output logic [MAG_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(MAG_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [MAG_W:0]    rem_ff, rem_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;

   logic [MAG_W:0]    shifted;
   logic [MAG_W+1:0]  trial;

   always_comb begin
      shifted = {rem_ff[MAG_W-1:0], quo_ff[MAG_W-1]};
      trial   = {1'b0, shifted} - {{(MAG_W + 2 - CNT_W){1'b0}}, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial[MAG_W+1]) begin
            rem_in = shifted;
            quo_in = {quo_ff[MAG_W-2:0], 1'b0};
         end else begin
            rem_in = trial[MAG_W:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b1};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: sv/line_follower_pid_motor_drive.sv
// Each accepted beat steps EVAL, DIV, MUL_P, MUL_I, MUL_D, ACC_I, ACC_D, MIX_L,
// MIX_R, DRV_R and DONE (a halted tick EVAL to DONE) before another is taken.
// The sequencer steps the divider and the shared 25x16 multiplier three times.
// A new beat is taken while the previous result still waits on rsp_ready.
// Synchronous active-high reset loads register defaults, clears control state.
`default_nettype none

module line_follower_pid_motor_drive import lfpid_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [SENSOR_W-1:0]     req_sensor_bits,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   rsp_left_dir,
   output logic [DUTY_W-1:0]            rsp_left_duty,
   output logic [1:0]                   rsp_right_dir,
   output logic [DUTY_W-1:0]            rsp_right_duty,
   output logic                         rsp_halted,
   output logic                         rsp_reversing,
   output logic signed [ERR_W-1:0]      rsp_line_error,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   // configuration
   logic signed [GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [DUTY_W-1:0]        base_speed_ff, recov_speed_ff, rev_drive_ff, brake_duty_ff;
   logic [LOST_W-1:0]        lost_limit_ff;

   // sequencer and state
   state_type                state_ff, state_in;
   logic [SENSOR_COUNT-1:0]  bits_ff;
   logic signed [ERR_W-1:0]  prev_err_ff, cur_err_ff;
   logic signed [INT_W-1:0]  integ_ff;
   logic [LOST_W-1:0]        lost_ff;
   logic                     halt_ff, recov_ff, rev_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, diff_ff;

   // result being built, then the output register
   motor_type                res_left_ff, res_right_ff;
   logic                     res_halted_ff;
   logic                     rsp_valid_ff;
   motor_type                rsp_left_ff, rsp_right_ff;
   logic                     rsp_halted_ff, rsp_rev_ff;
   logic signed [ERR_W-1:0]  rsp_err_ff;

   // combinational
   logic signed [SUM_W-1:0]  sum_v;
   logic [CNT_W-1:0]         cnt_v;
   logic [MAG_W-1:0]         sum_mag;
   logic                     halt_now, centre_none;
   logic [LOST_W-1:0]        lost_next;
   logic                     div_start, div_done;
   logic [MAG_W-1:0]         div_quo;
   logic signed [ERR_W-1:0]  quo_signed;
   logic signed [A_W-1:0]    mul_a;
   logic signed [GAIN_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [A_W-1:0]    integ_base, err_scaled;
   logic signed [SAT_W-1:0]  ishift;
   logic signed [INT_W-1:0]  integ_sat;
   logic signed [ACC_W-1:0]  base256;
   logic signed [LVL_W-1:0]  lvl_q, lvl_t, rev_lvl, lvl_sel;
   logic                     round_up;
   motor_type                motor_c;

   function automatic motor_type drive_map(input logic signed [LVL_W-1:0] lvl,
                                           input logic [DUTY_W-1:0] brk);
      motor_type               m;
      logic signed [LVL_W-1:0] neg;
      neg = -lvl;
      if (lvl > LVL_W'(0)) begin
         m.dir  = DIR_FWD;
         m.duty = (lvl > LVL_W'(255)) ? DUTY_MAX : lvl[DUTY_W-1:0];
      end else if (lvl == LVL_W'(0)) begin
         m.dir  = DIR_BRAKE;
         m.duty = brk;
      end else begin
         m.dir  = DIR_REV;
         m.duty = (neg > LVL_W'(255)) ? DUTY_MAX : neg[DUTY_W-1:0];
      end
      return m;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= RST_GAIN_P;
         gain_i_ff      <= RST_GAIN_I;
         gain_d_ff      <= RST_GAIN_D;
         base_speed_ff  <= RST_BASE_SPEED;
         recov_speed_ff <= RST_RECOVERY_SPEED;
         lost_limit_ff  <= RST_LOST_LIMIT;
         rev_drive_ff   <= RST_REVERSE_DRIVE;
         brake_duty_ff  <= RST_BRAKE_DUTY;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_P:         gain_p_ff      <= csr_wdata;
            CSR_GAIN_I:         gain_i_ff      <= csr_wdata;
            CSR_GAIN_D:         gain_d_ff      <= csr_wdata;
            CSR_BASE_SPEED:     base_speed_ff  <= csr_wdata[DUTY_W-1:0];
            CSR_RECOVERY_SPEED: recov_speed_ff <= csr_wdata[DUTY_W-1:0];
            CSR_LOST_LIMIT:     lost_limit_ff  <= csr_wdata[LOST_W-1:0];
            CSR_REVERSE_DRIVE:  rev_drive_ff   <= csr_wdata[DUTY_W-1:0];
            CSR_BRAKE_DUTY:     brake_duty_ff  <= csr_wdata[DUTY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sensor decode
   always_comb begin
      sum_v = SUM_W'(0);
      cnt_v = '0;
      for (int k = 0; k < SENSOR_COUNT; k++) begin
         sum_v = sum_v + (bits_ff[k] ? SUM_W'(CENTRE - k) : SUM_W'(0));
         cnt_v = cnt_v + CNT_W'(bits_ff[k]);
      end
      sum_mag     = sum_v[SUM_W-1] ? MAG_W'(-sum_v) : MAG_W'(sum_v);
      halt_now    = halt_ff || ((bits_ff & CENTRE_MASK) == CENTRE_MASK);
      centre_none = (bits_ff & CENTRE_MASK) == '0;
      lost_next   = (lost_ff == LOST_MAX) ? lost_ff : lost_ff + 1'b1;
      quo_signed  = sum_v[SUM_W-1] ? -$signed(div_quo) : $signed(div_quo);
   end

   lfpid_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (cnt_v),
      .done     (div_done),
      .quotient (div_quo)
   );

   // shared multiplier operands, integral saturation, level rounding
   always_comb begin
      err_scaled = $signed({{(A_W - ERR_W - 8){cur_err_ff[ERR_W-1]}}, cur_err_ff, 8'b0});
      integ_base = (cur_err_ff == '0) ? A_W'(0) : A_W'(integ_ff);
      mul_p      = mul_a * mul_b;
      ishift     = prod_ff[PROD_W-1:8];
      if (ishift > SAT_W'(INT_MAX_V)) begin
         integ_sat = INT_W'(INT_MAX_V);
      end else if (ishift < SAT_W'(INT_MIN_V)) begin
         integ_sat = INT_W'(INT_MIN_V);
      end else begin
         integ_sat = ishift[INT_W-1:0];
      end
      base256  = $signed({{(ACC_W - DUTY_W - 8){1'b0}},
                          (recov_ff ? recov_speed_ff : base_speed_ff), 8'b0});
      // truncate toward zero: bump negative values with a fraction
      lvl_q    = diff_ff[ACC_W-1:8];
      round_up = diff_ff[ACC_W-1] && (diff_ff[7:0] != 8'd0);
      lvl_t    = lvl_q + $signed({{(LVL_W - 1){1'b0}}, round_up});
      rev_lvl  = -$signed({{(LVL_W - DUTY_W){1'b0}}, rev_drive_ff});
      lvl_sel  = rev_ff ? rev_lvl : lvl_t;
      motor_c  = drive_map(lvl_sel, brake_duty_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_EVAL;
         ST_EVAL:  state_in = halt_now ? ST_DONE : ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_MUL_P;
         ST_MUL_P: state_in = ST_MUL_I;
         ST_MUL_I: state_in = ST_MUL_D;
         ST_MUL_D: state_in = ST_ACC_I;
         ST_ACC_I: state_in = ST_ACC_D;
         ST_ACC_D: state_in = ST_MIX_L;
         ST_MIX_L: state_in = ST_MIX_R;
         ST_MIX_R: state_in = ST_DRV_R;
         ST_DRV_R: state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      mul_a     = A_W'(cur_err_ff);
      mul_b     = gain_p_ff;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_EVAL:  div_start = !halt_now;
         ST_MUL_P: begin
            mul_a = A_W'(cur_err_ff);
            mul_b = gain_p_ff;
         end
         ST_MUL_I: begin
            mul_a = integ_base + err_scaled;
            mul_b = gain_i_ff;
         end
         ST_MUL_D: begin
            mul_a = A_W'(cur_err_ff) - A_W'(prev_err_ff);
            mul_b = gain_d_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff  <= '0;
         cur_err_ff   <= '0;
         integ_ff     <= '0;
         lost_ff      <= '0;
         halt_ff      <= 1'b0;
         recov_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_EVAL: begin
               if (halt_now) begin
                  halt_ff <= 1'b1;
               end else if (centre_none) begin
                  lost_ff <= lost_next;
                  if (lost_next > lost_limit_ff) begin
                     recov_ff <= 1'b1;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  prev_err_ff <= cur_err_ff;
                  if (cnt_v != '0) begin
                     cur_err_ff <= quo_signed;
                  end
               end
            end
            ST_MUL_D: integ_ff <= integ_sat;
            default: begin
            end
         endcase
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               bits_ff <= req_sensor_bits[SENSOR_COUNT-1:0];
            end
         end
         ST_EVAL: begin
            res_halted_ff <= halt_now;
            rev_ff        <= !halt_now && centre_none && (lost_next > lost_limit_ff);
            if (halt_now) begin
               res_left_ff  <= '{dir: DIR_BRAKE, duty: brake_duty_ff};
               res_right_ff <= '{dir: DIR_BRAKE, duty: brake_duty_ff};
            end
         end
         ST_MUL_P: prod_ff <= mul_p;
         ST_MUL_I: begin
            acc_ff  <= prod_ff[ACC_W-1:0];
            prod_ff <= mul_p;
         end
         ST_MUL_D: prod_ff <= mul_p;
         ST_ACC_I: acc_ff  <= acc_ff + ACC_W'(integ_ff);
         ST_ACC_D: acc_ff  <= acc_ff + prod_ff[ACC_W-1:0];
         ST_MIX_L: diff_ff <= base256 - acc_ff;
         ST_MIX_R: begin
            res_left_ff <= motor_c;
            diff_ff     <= base256 + acc_ff;
         end
         ST_DRV_R: res_right_ff <= motor_c;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_left_ff   <= res_left_ff;
               rsp_right_ff  <= res_right_ff;
               rsp_halted_ff <= res_halted_ff;
               rsp_rev_ff    <= rev_ff && !res_halted_ff;
               rsp_err_ff    <= cur_err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_left_dir   = rsp_left_ff.dir;
   assign rsp_left_duty  = rsp_left_ff.duty;
   assign rsp_right_dir  = rsp_right_ff.dir;
   assign rsp_right_duty = rsp_right_ff.duty;
   assign rsp_halted     = rsp_halted_ff;
   assign rsp_reversing  = rsp_rev_ff;
   assign rsp_line_error = rsp_err_ff;

endmodule

`default_nettype wire

// File: sv/lfpid_checker.sv
`default_nettype none

module lfpid_checker import lfpid_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [1:0]            rsp_left_dir,
   input wire logic [DUTY_W-1:0]     rsp_left_duty,
   input wire logic [1:0]            rsp_right_dir,
   input wire logic [DUTY_W-1:0]     rsp_right_duty,
   input wire logic                  rsp_halted,
   input wire logic                  rsp_reversing,
   input wire logic [ERR_W-1:0]      rsp_line_error
);

   logic halt_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         halt_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_halted) begin
         halt_seen_ff <= 1'b1;
      end
   end

   // a halted beat brakes both motors at the same duty
   a_halt_brakes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_halted |->
         rsp_left_dir == DIR_BRAKE && rsp_right_dir == DIR_BRAKE &&
         rsp_left_duty == rsp_right_duty && !rsp_reversing)
      else $error("halted beat not braking both motors");

   // halt stays latched until reset
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && halt_seen_ff |-> rsp_halted)
      else $error("beat after a halt is not halted");

   // reverse recovery drives both motors alike, never forward
   a_rev_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reversing |->
         rsp_left_dir == rsp_right_dir && rsp_left_duty == rsp_right_duty &&
         rsp_left_dir != DIR_FWD)
      else $error("reverse beat with unequal or forward motors");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_left_duty) && $stable(rsp_right_duty) &&
         $stable(rsp_line_error))
      else $error("stalled result beat changed");

endmodule

bind line_follower_pid_motor_drive lfpid_checker u_lfpid_checker (.*);

`default_nettype wire
